// ===== hdl/kcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_pkg
// Shared types, field widths and codes of the k-means cluster ranking block.
// ----------------------------------------------------------------------------
package kcr_pkg;

   localparam int MAX_POINTS_C   = 4096;
   localparam int MAX_DIMS_C     = 8;
   localparam int MAX_CLUSTERS_C = 16;

   // Field widths of the channels.
   localparam int OP_W       = 2;
   localparam int COORD_W    = 16;
   localparam int PIDX_W     = 12;
   localparam int CRANK_W    = 4;
   localparam int DIDX_W     = 3;
   localparam int PRANK_W    = 4;
   localparam int CENT_W     = 24;
   localparam int MCOUNT_W   = 13;
   localparam int PASSES_W   = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam int NCLUS_W  = 5;
   localparam int NDIMS_W  = 4;
   localparam int THRESH_W = 63;
   localparam int ERR_W    = 64;

   // Previous error at the start of every run.
   localparam logic [ERR_W-1:0] ERR_START_C = 64'd999999999 << 16;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 2'd0,
      OP_RUN     = 2'd1,
      OP_READ_PT = 2'd2,
      OP_READ_CL = 2'd3
   } kcr_op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_CLUSTERS   = 2'd0,
      CSR_NUM_DIMS       = 2'd1,
      CSR_THRESHOLD      = 2'd2,
      CSR_MAX_ITERATIONS = 2'd3
   } kcr_csr_type;

   // Control of the squared distance unit.
   typedef struct packed {
      logic clr;
      logic en;
   } kcr_mac_ctl_type;

endpackage
`default_nettype wire

// ===== hdl/kcr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kcr_req_if import kcr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   kcr_op_type           op;
   logic [COORD_W-1:0]   coord_value;
   logic [PIDX_W-1:0]    point_index;
   logic [CRANK_W-1:0]   cluster_rank;
   logic [DIDX_W-1:0]    dim_index;

   modport source (output valid, op, coord_value, point_index, cluster_rank, dim_index,
                   input ready);
   modport sink (input valid, op, coord_value, point_index, cluster_rank, dim_index,
                 output ready);
endinterface

interface kcr_rsp_if import kcr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PRANK_W-1:0]   point_rank;
   logic [CENT_W-1:0]    centroid_value;
   logic [MCOUNT_W-1:0]  member_count;
   logic [PASSES_W-1:0]  passes_run;
   logic                 hit_limit;

   modport source (output valid, point_rank, centroid_value, member_count, passes_run,
                   hit_limit, input ready);
   modport sink (input valid, point_rank, centroid_value, member_count, passes_run,
                 hit_limit, output ready);
endinterface

interface kcr_csr_if import kcr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/kcr_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module kcr_divider import kcr_pkg::*; #(
   parameter int NUM_W = 38,
   parameter int DEN_W = 13
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [NUM_W-1:0] quo,
   output logic                  done
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   shifted;
   logic             take;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign take    = shifted >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], take};
         rem_ff <= take ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// ===== hdl/kcr_dist_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_dist_mac
// Squared distance unit: absolute difference, square and accumulate, one term
// per cycle through three register stages.
// ----------------------------------------------------------------------------
module kcr_dist_mac import kcr_pkg::*; #(
   parameter int ACC_W = 52
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire kcr_mac_ctl_type   ctl,
   input  wire logic [COORD_W-1:0] coord,
   input  wire logic [CENT_W-1:0] cent,
   output logic      [ACC_W-1:0]  acc,
   output logic                   idle
);
   logic [CENT_W-1:0]   diff_ff;
   logic [2*CENT_W-1:0] sq_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic                v1_ff;
   logic                v2_ff;
   logic [CENT_W-1:0]   pval;

   assign pval = {coord, 8'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= ctl.en;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= (pval > cent) ? pval - cent : cent - pval;
      sq_ff   <= diff_ff * diff_ff;
      if (ctl.clr) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(sq_ff);
      end
   end

   assign acc  = acc_ff;
   assign idle = !v1_ff && !v2_ff;
endmodule
`default_nettype wire

// ===== hdl/kmeans_cluster_rank_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kmeans_cluster_rank_top
// Lloyd k-means clustering of loaded points with clusters ranked by centroid
// coordinate sum.
// ----------------------------------------------------------------------------
// Usage: points are loaded through req_if one coordinate per transfer (op 0),
// one transfer per cycle, with no response. Op 1 runs the clustering and
// returns passes_run and hit_limit; op 2 returns a point's rank; op 3 returns
// a ranked cluster's centroid coordinate and member count. The user must write
// csr_if's four registers only while the block is idle; the block does not
// enforce it, and csr_if is always ready. A point read passes ST_RD_PT and a
// cluster read ST_RD_CL0 and ST_RD_CL1 before ST_OUT registers the response.
// A run walks all points and clusters through one shared squared distance
// unit, one coordinate per cycle while a cluster's distances stream, with
// seeding before the passes and ranking of the clusters after them.
// req_if.ready is low while an item is at work. The response sits in an
// output register; a stalled receiver holds the block only when a further
// response must be placed. Reset clears control state and registers; stores
// that hold run results need no clearing, as reads check the last run's sizes.
// ----------------------------------------------------------------------------
module kmeans_cluster_rank_top import kcr_pkg::*; #(
   parameter int MAX_POINTS   = MAX_POINTS_C,
   parameter int MAX_DIMS     = MAX_DIMS_C,
   parameter int MAX_CLUSTERS = MAX_CLUSTERS_C
) (
   input wire logic  clock,
   input wire logic  reset,
   kcr_req_if.sink   req_if,
   kcr_rsp_if.source rsp_if,
   kcr_csr_if.sink   csr_if
);
   localparam int PW   = $clog2(MAX_POINTS);
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int DW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DCW  = $clog2(MAX_DIMS + 1);
   localparam int KW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int KCW  = $clog2(MAX_CLUSTERS + 1);
   localparam int SW   = COORD_W + CW;
   localparam int NW   = SW + 9;
   localparam int AW   = 2 * CENT_W + DW + 1;
   localparam int SCW  = CENT_W + DCW;
   localparam int CAW  = KW + DW;

   typedef enum logic [24:0] {
      ST_IDLE     = 25'd1 << 0,
      ST_RUN0     = 25'd1 << 1,
      ST_STEP     = 25'd1 << 2,
      ST_SEED_RD  = 25'd1 << 3,
      ST_SEED_WR  = 25'd1 << 4,
      ST_CLR      = 25'd1 << 5,
      ST_DIST     = 25'd1 << 6,
      ST_DRAIN    = 25'd1 << 7,
      ST_ASSIGN   = 25'd1 << 8,
      ST_SUM_RD   = 25'd1 << 9,
      ST_SUM_WR   = 25'd1 << 10,
      ST_CEN_RD   = 25'd1 << 11,
      ST_CEN_GO   = 25'd1 << 12,
      ST_CEN_WAIT = 25'd1 << 13,
      ST_CHECK    = 25'd1 << 14,
      ST_SC_RD    = 25'd1 << 15,
      ST_SC_ACC   = 25'd1 << 16,
      ST_SORT_LD  = 25'd1 << 17,
      ST_SORT_CMP = 25'd1 << 18,
      ST_SORT_WB  = 25'd1 << 19,
      ST_RMAP     = 25'd1 << 20,
      ST_RD_PT    = 25'd1 << 21,
      ST_RD_CL0   = 25'd1 << 22,
      ST_RD_CL1   = 25'd1 << 23,
      ST_OUT      = 25'd1 << 24
   } kcr_state_type;

   // Configuration registers.
   logic [NCLUS_W-1:0]  nc_ff;
   logic [NDIMS_W-1:0]  nd_ff;
   logic [THRESH_W-1:0] thr_ff;
   logic [PASSES_W-1:0] maxit_ff;

   // Memories and their registered read data.
   logic [COORD_W-1:0] pt_mem  [2**(PW+DW)];
   logic [KW-1:0]      lbl_mem [2**PW];
   logic [CENT_W-1:0]  cen_mem [2**CAW];
   logic [SW-1:0]      sum_mem [2**CAW];
   logic [COORD_W-1:0] pt_rd_ff;
   logic [KW-1:0]      lbl_rd_ff;
   logic [CENT_W-1:0]  cen_rd_ff;
   logic [SW-1:0]      sum_rd_ff;

   // Per-cluster register arrays.
   logic [CW-1:0]  sz_ff    [MAX_CLUSTERS];
   logic [SCW-1:0] score_ff [MAX_CLUSTERS];
   logic [KW-1:0]  car_ff   [MAX_CLUSTERS];
   logic [KW-1:0]  rank_ff  [MAX_CLUSTERS];

   kcr_state_type state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [DCW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]       n_ff, n_in, run_n_ff, run_n_in, step_ff, step_in;
   logic [KCW-1:0]      k_ff, k_in, run_k_ff, run_k_in;
   logic [DCW-1:0]      d_ff, d_in, run_d_ff, run_d_in;
   logic [PW-1:0]       h_ff, h_in, idx_ff, idx_in;
   logic [KW-1:0]       i_ff, i_in, s_ff, s_in, best_ff, best_in, c_ff, c_in;
   logic [KW-1:0]       cur_c_ff, cur_c_in;
   logic [DW-1:0]       j_ff, j_in;
   logic [CAW-1:0]      sweep_ff, sweep_in;
   logic [AW-1:0]       bd_ff, bd_in;
   logic [ERR_W-1:0]    err_ff, err_in, prev_ff, prev_in;
   logic [PASSES_W-1:0] passes_ff, passes_in;
   logic                hit_ff, hit_in, rd_vld_ff, rd_vld_in;
   logic [SCW-1:0]      sacc_ff, sacc_in, cur_s_ff, cur_s_in;
   logic [PIDX_W-1:0]   q_pi_ff, q_pi_in;
   logic [CRANK_W-1:0]  q_r_ff, q_r_in;
   logic [DIDX_W-1:0]   q_dj_ff, q_dj_in;
   logic [PRANK_W-1:0]  res_rank_ff, res_rank_in;
   logic [CENT_W-1:0]   res_cent_ff, res_cent_in;
   logic [MCOUNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic [PASSES_W-1:0] res_pass_ff, res_pass_in;
   logic                res_hit_ff, res_hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PRANK_W-1:0]  rsp_rank_ff, rsp_rank_in;
   logic [CENT_W-1:0]   rsp_cent_ff, rsp_cent_in;
   logic [MCOUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic [PASSES_W-1:0] rsp_pass_ff, rsp_pass_in;
   logic                rsp_hit_ff, rsp_hit_in;

   // Memory and array access controls.
   logic                pt_we, cen_we, sum_we, lbl_we, sc_we, rk_we, sz_clr, sz_inc;
   logic [PW+DW-1:0]    pt_wa, pt_ra;
   logic [COORD_W-1:0]  pt_wd;
   logic [CAW-1:0]      cen_wa, cen_ra, sum_wa, sum_ra;
   logic [CENT_W-1:0]   cen_wd;
   logic [SW-1:0]       sum_wd;
   logic [KW-1:0]       sc_wa, car_wd, sc_ra, car_ra, sz_ra;
   logic [SCW-1:0]      sc_wd;
   logic [SCW-1:0]      sc_rd;
   logic [KW-1:0]       car_rd;
   logic [CW-1:0]       sz_rd;

   // Shared units.
   logic                div_start, div_done;
   logic [NW-1:0]       div_num, div_quo;
   logic [CW-1:0]       div_den;
   kcr_mac_ctl_type     mac_ctl;
   logic [AW-1:0]       mac_acc;
   logic                mac_idle;

   // Derived values.
   logic [DCW-1:0]      d_eff;
   logic [31:0]         k_tmp;
   logic [PASSES_W-1:0] cap;
   logic                req_fire, rsp_free;
   logic                j_last, i_last, h_last, s_last;
   logic [DCW-1:0]      pos0, pos1;
   logic [ERR_W:0]      err_sum;
   logic [ERR_W-1:0]    err_diff;
   logic [SCW-1:0]      sc_sum;

   kcr_divider #(.NUM_W(NW), .DEN_W(CW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   kcr_dist_mac #(.ACC_W(AW)) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .coord (pt_rd_ff),
      .cent  (cen_rd_ff),
      .acc   (mac_acc),
      .idle  (mac_idle)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.point_rank     = rsp_rank_ff;
   assign rsp_if.centroid_value = rsp_cent_ff;
   assign rsp_if.member_count   = rsp_cnt_ff;
   assign rsp_if.passes_run     = rsp_pass_ff;
   assign rsp_if.hit_limit      = rsp_hit_ff;

   always_comb begin
      if (nd_ff == '0) begin
         d_eff = DCW'(1);
      end else if (32'(nd_ff) > 32'(MAX_DIMS)) begin
         d_eff = DCW'(MAX_DIMS);
      end else begin
         d_eff = DCW'(nd_ff);
      end
      k_tmp = (nc_ff == '0) ? 32'd1 : 32'(nc_ff);
      if (k_tmp > 32'(MAX_CLUSTERS)) begin
         k_tmp = 32'(MAX_CLUSTERS);
      end
      if (k_tmp > 32'(cnt_ff)) begin
         k_tmp = 32'(cnt_ff);
      end
   end

   assign cap    = (maxit_ff == '0) ? PASSES_W'(1) : maxit_ff;
   assign j_last = (32'(j_ff) == 32'(d_ff) - 32'd1);
   assign i_last = (32'(i_ff) == 32'(k_ff) - 32'd1);
   assign h_last = (32'(h_ff) == 32'(n_ff) - 32'd1);
   assign s_last = (32'(s_ff) == 32'(k_ff) - 32'd1);
   assign pos0   = (pos_ff >= d_eff) ? d_eff - 1'b1 : pos_ff;
   assign pos1   = pos0 + 1'b1;
   assign err_sum  = {1'b0, err_ff} + (ERR_W + 1)'(bd_ff);
   assign err_diff = (err_ff > prev_ff) ? err_ff - prev_ff : prev_ff - err_ff;
   assign sc_sum   = sacc_ff + SCW'(cen_rd_ff);

   // Read address selection for the memories and arrays.
   assign pt_ra  = (state_ff == ST_SEED_RD) ? {idx_ff, j_ff} : {h_ff, j_ff};
   assign cen_ra = (state_ff == ST_RD_CL0) ? {car_rd, DW'(q_dj_ff)} : {i_ff, j_ff};
   assign sum_ra = (state_ff == ST_SUM_RD) ? {best_ff, j_ff} : {i_ff, j_ff};
   assign sc_ra  = (state_ff == ST_SORT_CMP) ? s_ff : i_ff;
   always_comb begin
      case (state_ff)
         ST_SORT_CMP: car_ra = s_ff;
         ST_RD_CL0:   car_ra = KW'(q_r_ff);
         default:     car_ra = i_ff;
      endcase
      case (state_ff)
         ST_ASSIGN: sz_ra = best_ff;
         ST_RD_CL1: sz_ra = c_ff;
         default:   sz_ra = i_ff;
      endcase
   end
   assign sc_rd  = score_ff[sc_ra];
   assign car_rd = car_ff[car_ra];
   assign sz_rd  = sz_ff[sz_ra];

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      n_in        = n_ff;
      k_in        = k_ff;
      d_in        = d_ff;
      run_n_in    = run_n_ff;
      run_k_in    = run_k_ff;
      run_d_in    = run_d_ff;
      step_in     = step_ff;
      h_in        = h_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      s_in        = s_ff;
      idx_in      = idx_ff;
      sweep_in    = sweep_ff;
      best_in     = best_ff;
      bd_in       = bd_ff;
      err_in      = err_ff;
      prev_in     = prev_ff;
      passes_in   = passes_ff;
      hit_in      = hit_ff;
      sacc_in     = sacc_ff;
      cur_s_in    = cur_s_ff;
      cur_c_in    = cur_c_ff;
      rd_vld_in   = 1'b0;
      q_pi_in     = q_pi_ff;
      q_r_in      = q_r_ff;
      q_dj_in     = q_dj_ff;
      c_in        = c_ff;
      res_rank_in = res_rank_ff;
      res_cent_in = res_cent_ff;
      res_cnt_in  = res_cnt_ff;
      res_pass_in = res_pass_ff;
      res_hit_in  = res_hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_rank_in  = rsp_rank_ff;
      rsp_cent_in  = rsp_cent_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_pass_in  = rsp_pass_ff;
      rsp_hit_in   = rsp_hit_ff;
      pt_we  = 1'b0;
      pt_wa  = {cnt_ff[PW-1:0], DW'(pos0)};
      pt_wd  = req_if.coord_value;
      cen_we = 1'b0;
      cen_wa = {i_ff, j_ff};
      cen_wd = '0;
      sum_we = 1'b0;
      sum_wa = sweep_ff;
      sum_wd = '0;
      lbl_we = 1'b0;
      sc_we  = 1'b0;
      sc_wa  = i_ff;
      sc_wd  = cur_s_ff;
      car_wd = cur_c_ff;
      rk_we  = 1'b0;
      sz_clr = 1'b0;
      sz_inc = 1'b0;
      div_start = 1'b0;
      div_num   = NW'(cnt_ff);
      div_den   = CW'(k_tmp);
      mac_ctl.clr = 1'b0;
      mac_ctl.en  = rd_vld_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_if.op)
                  OP_LOAD: begin
                     if (32'(cnt_ff) < 32'(MAX_POINTS)) begin
                        pt_we = 1'b1;
                        if (pos1 >= d_eff) begin
                           pos_in = '0;
                           cnt_in = cnt_ff + 1'b1;
                        end else begin
                           pos_in = pos1;
                        end
                     end
                  end
                  OP_RUN: begin
                     state_in = ST_RUN0;
                  end
                  OP_READ_PT: begin
                     q_pi_in  = req_if.point_index;
                     state_in = ST_RD_PT;
                  end
                  default: begin
                     q_r_in   = req_if.cluster_rank;
                     q_dj_in  = req_if.dim_index;
                     state_in = ST_RD_CL0;
                  end
               endcase
            end
         end
         ST_RUN0: begin
            passes_in = '0;
            hit_in    = 1'b0;
            if (cnt_ff == '0) begin
               run_n_in    = '0;
               run_k_in    = '0;
               run_d_in    = '0;
               res_rank_in = '0;
               res_cent_in = '0;
               res_cnt_in  = '0;
               res_pass_in = '0;
               res_hit_in  = 1'b0;
               state_in    = ST_OUT;
            end else begin
               n_in      = cnt_ff;
               k_in      = KCW'(k_tmp);
               d_in      = d_eff;
               div_start = 1'b1;
               state_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            if (div_done) begin
               step_in  = CW'(div_quo);
               i_in     = '0;
               j_in     = '0;
               idx_in   = '0;
               state_in = ST_SEED_RD;
            end
         end
         ST_SEED_RD: begin
            state_in = ST_SEED_WR;
         end
         ST_SEED_WR: begin
            cen_we = 1'b1;
            cen_wd = {pt_rd_ff, 8'd0};
            state_in = ST_SEED_RD;
            if (j_last) begin
               j_in   = '0;
               idx_in = idx_ff + PW'(step_ff);
               if (i_last) begin
                  prev_in  = ERR_START_C;
                  err_in   = '0;
                  sweep_in = '0;
                  state_in = ST_CLR;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_CLR: begin
            // Sweep the sum store while the sizes clear at once.
            sum_we      = 1'b1;
            sz_clr      = 1'b1;
            mac_ctl.clr = 1'b1;
            sweep_in    = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               h_in     = '0;
               i_in     = '0;
               j_in     = '0;
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            rd_vld_in = 1'b1;
            if (j_last) begin
               j_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && mac_idle) begin
               mac_ctl.clr = 1'b1;
               if (i_ff == '0 || mac_acc < bd_ff) begin
                  bd_in   = mac_acc;
                  best_in = i_ff;
               end
               if (i_last) begin
                  state_in = ST_ASSIGN;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_DIST;
               end
            end
         end
         ST_ASSIGN: begin
            lbl_we   = 1'b1;
            sz_inc   = 1'b1;
            err_in   = err_sum[ERR_W] ? '1 : err_sum[ERR_W-1:0];
            i_in     = '0;
            j_in     = '0;
            state_in = ST_SUM_RD;
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_WR;
         end
         ST_SUM_WR: begin
            sum_we   = 1'b1;
            sum_wa   = {best_ff, j_ff};
            sum_wd   = sum_rd_ff + SW'(pt_rd_ff);
            state_in = ST_SUM_RD;
            if (j_last) begin
               j_in = '0;
               if (h_last) begin
                  i_in     = '0;
                  state_in = ST_CEN_RD;
               end else begin
                  h_in     = h_ff + 1'b1;
                  state_in = ST_DIST;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_CEN_RD: begin
            state_in = ST_CEN_GO;
         end
         ST_CEN_GO, ST_CEN_WAIT: begin
            if (state_ff == ST_CEN_GO && sz_rd != '0) begin
               div_start = 1'b1;
               div_num   = (NW'(sum_rd_ff) << 8) + NW'(sz_rd >> 1);
               div_den   = sz_rd;
               state_in  = ST_CEN_WAIT;
            end else if (state_ff == ST_CEN_GO || div_done) begin
               // Empty clusters get a zero centroid.
               cen_we   = 1'b1;
               cen_wd   = (state_ff == ST_CEN_GO) ? '0 : CENT_W'(div_quo);
               state_in = ST_CEN_RD;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = ST_CHECK;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_CHECK: begin
            passes_in = passes_ff + 1'b1;
            i_in      = '0;
            j_in      = '0;
            sacc_in   = '0;
            if (err_diff <= {1'b0, thr_ff}) begin
               state_in = ST_SC_RD;
            end else if (passes_ff + 1'b1 >= cap) begin
               hit_in   = 1'b1;
               state_in = ST_SC_RD;
            end else begin
               prev_in  = err_ff;
               err_in   = '0;
               sweep_in = '0;
               state_in = ST_CLR;
            end
         end
         ST_SC_RD: begin
            state_in = ST_SC_ACC;
         end
         ST_SC_ACC: begin
            state_in = ST_SC_RD;
            if (j_last) begin
               sc_we   = 1'b1;
               sc_wd   = sc_sum;
               car_wd  = i_ff;
               sacc_in = '0;
               j_in    = '0;
               if (i_last) begin
                  i_in     = '0;
                  state_in = (k_ff == KCW'(1)) ? ST_RMAP : ST_SORT_LD;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               sacc_in = sc_sum;
               j_in    = j_ff + 1'b1;
            end
         end
         ST_SORT_LD: begin
            cur_s_in = sc_rd;
            cur_c_in = car_rd;
            s_in     = i_ff + 1'b1;
            state_in = ST_SORT_CMP;
         end
         ST_SORT_CMP: begin
            // A strictly smaller later score swaps into the held position.
            if (sc_rd < cur_s_ff) begin
               sc_we    = 1'b1;
               sc_wa    = s_ff;
               cur_s_in = sc_rd;
               cur_c_in = car_rd;
            end
            if (s_last) begin
               state_in = ST_SORT_WB;
            end else begin
               s_in = s_ff + 1'b1;
            end
         end
         ST_SORT_WB: begin
            sc_we = 1'b1;
            if (32'(i_ff) + 32'd2 >= 32'(k_ff)) begin
               i_in     = '0;
               state_in = ST_RMAP;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SORT_LD;
            end
         end
         ST_RMAP: begin
            rk_we = 1'b1;
            if (i_last) begin
               run_n_in    = n_ff;
               run_k_in    = k_ff;
               run_d_in    = d_ff;
               res_rank_in = '0;
               res_cent_in = '0;
               res_cnt_in  = '0;
               res_pass_in = passes_ff;
               res_hit_in  = hit_ff;
               state_in    = ST_OUT;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_RD_PT: begin
            res_rank_in = (32'(q_pi_ff) < 32'(run_n_ff)) ? PRANK_W'(rank_ff[lbl_rd_ff]) : '0;
            res_cent_in = '0;
            res_cnt_in  = '0;
            res_pass_in = '0;
            res_hit_in  = 1'b0;
            state_in    = ST_OUT;
         end
         ST_RD_CL0: begin
            c_in     = car_rd;
            state_in = ST_RD_CL1;
         end
         ST_RD_CL1: begin
            res_rank_in = '0;
            res_pass_in = '0;
            res_hit_in  = 1'b0;
            res_cent_in = '0;
            res_cnt_in  = '0;
            if (32'(q_r_ff) < 32'(run_k_ff)) begin
               res_cnt_in = MCOUNT_W'(sz_rd);
               if (32'(q_dj_ff) < 32'(run_d_ff)) begin
                  res_cent_in = cen_rd_ff;
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_rank_in  = res_rank_ff;
               rsp_cent_in  = res_cent_ff;
               rsp_cnt_in   = res_cnt_ff;
               rsp_pass_in  = res_pass_ff;
               rsp_hit_in   = res_hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         run_n_ff     <= '0;
         run_k_ff     <= '0;
         run_d_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         nc_ff        <= NCLUS_W'(2);
         nd_ff        <= NDIMS_W'(1);
         thr_ff       <= '0;
         maxit_ff     <= '1;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         run_n_ff     <= run_n_in;
         run_k_ff     <= run_k_in;
         run_d_ff     <= run_d_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_NUM_CLUSTERS:   nc_ff    <= csr_if.data[NCLUS_W-1:0];
               CSR_NUM_DIMS:       nd_ff    <= csr_if.data[NDIMS_W-1:0];
               CSR_THRESHOLD:      thr_ff   <= csr_if.data[THRESH_W-1:0];
               CSR_MAX_ITERATIONS: maxit_ff <= csr_if.data[PASSES_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      d_ff        <= d_in;
      step_ff     <= step_in;
      h_ff        <= h_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      s_ff        <= s_in;
      idx_ff      <= idx_in;
      sweep_ff    <= sweep_in;
      best_ff     <= best_in;
      bd_ff       <= bd_in;
      err_ff      <= err_in;
      prev_ff     <= prev_in;
      passes_ff   <= passes_in;
      hit_ff      <= hit_in;
      sacc_ff     <= sacc_in;
      cur_s_ff    <= cur_s_in;
      cur_c_ff    <= cur_c_in;
      q_pi_ff     <= q_pi_in;
      q_r_ff      <= q_r_in;
      q_dj_ff     <= q_dj_in;
      c_ff        <= c_in;
      res_rank_ff <= res_rank_in;
      res_cent_ff <= res_cent_in;
      res_cnt_ff  <= res_cnt_in;
      res_pass_ff <= res_pass_in;
      res_hit_ff  <= res_hit_in;
      rsp_rank_ff <= rsp_rank_in;
      rsp_cent_ff <= rsp_cent_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_pass_ff <= rsp_pass_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   // Memories.
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_wa] <= pt_wd;
      end
      pt_rd_ff <= pt_mem[pt_ra];
   end

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         lbl_mem[h_ff] <= best_ff;
      end
      lbl_rd_ff <= lbl_mem[PW'(req_if.point_index)];
   end

   always_ff @(posedge clock) begin
      if (cen_we) begin
         cen_mem[cen_wa] <= cen_wd;
      end
      cen_rd_ff <= cen_mem[cen_ra];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_wa] <= sum_wd;
      end
      sum_rd_ff <= sum_mem[sum_ra];
   end

   // Per-cluster arrays.
   always_ff @(posedge clock) begin
      for (int m = 0; m < MAX_CLUSTERS; m++) begin
         if (sz_clr) begin
            sz_ff[m] <= '0;
         end
      end
      if (sz_inc) begin
         sz_ff[best_ff] <= sz_rd + 1'b1;
      end
      if (sc_we) begin
         score_ff[sc_wa] <= sc_wd;
         car_ff[sc_wa]   <= car_wd;
      end
      if (rk_we) begin
         rank_ff[car_rd] <= i_ff;
      end
   end

endmodule
`default_nettype wire
